// ===== design/scf_pkg.sv =====
package scf_pkg;

    // Channels are packed with red in the lowest byte.
    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } rgb_t;

    // One line buffer entry: the pixel of row r-2 and of row r-1 at a column.
    typedef struct packed {
        rgb_t above;
        rgb_t centre;
    } line_entry_t;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;

    localparam int CFG_WIDTH_BITS  = 11;
    localparam int CFG_HEIGHT_BITS = 16;

endpackage

// ===== design/scf_line_buf.sv =====
module scf_line_buf #(
    parameter int DEPTH = 1024
) (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [$clog2(DEPTH)-1:0]     wr_addr,
    input  scf_pkg::line_entry_t         wr_data,
    input  logic                         rd_en,
    input  logic [$clog2(DEPTH)-1:0]     rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0]     rd_addr_b,
    output scf_pkg::line_entry_t         rd_data_a,
    output scf_pkg::line_entry_t         rd_data_b
);
    import scf_pkg::*;

    line_entry_t mem [DEPTH];
    line_entry_t rd_a_reg;
    line_entry_t rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // A read of the address written in the same cycle returns the new entry.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr_a))
            begin
                rd_a_reg <= wr_data;
            end
            else
            begin
                rd_a_reg <= mem[rd_addr_a];
            end
            if (wr_en && (wr_addr == rd_addr_b))
            begin
                rd_b_reg <= wr_data;
            end
            else
            begin
                rd_b_reg <= mem[rd_addr_b];
            end
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

// ===== design/scf_kernel.sv =====
module scf_kernel (
    input  scf_pkg::rgb_t up,
    input  scf_pkg::rgb_t ctr,
    input  scf_pkg::rgb_t down,
    input  scf_pkg::rgb_t lft,
    input  scf_pkg::rgb_t rgt,
    output scf_pkg::rgb_t pix
);
    import scf_pkg::*;

    function automatic logic [7:0] sharpen_chan(
        input logic [7:0] u,
        input logic [7:0] c,
        input logic [7:0] d,
        input logic [7:0] l,
        input logic [7:0] r
    );
        logic signed [11:0] v;
        logic [7:0] res;
        v = $signed({2'b00, c, 2'b00}) + $signed({4'b0000, c})
          - $signed({4'b0000, u}) - $signed({4'b0000, d})
          - $signed({4'b0000, l}) - $signed({4'b0000, r});
        priority if (v < 12'sd0)
        begin
            res = 8'd0;
        end
        else if (v > 12'sd255)
        begin
            res = 8'd255;
        end
        else
        begin
            res = v[7:0];
        end
        return res;
    endfunction

    always_comb
    begin
        pix.red   = sharpen_chan(up.red, ctr.red, down.red, lft.red, rgt.red);
        pix.green = sharpen_chan(up.green, ctr.green, down.green, lft.green, rgt.green);
        pix.blue  = sharpen_chan(up.blue, ctr.blue, down.blue, lft.blue, rgt.blue);
    end

endmodule

// ===== design/sharpen_cross_kernel_filter_core.sv =====
// Channel  Dir  Handshake            Payload
// s_       in   s_tvalid/s_tready    tdata: red, green, blue; tuser: opcode
// m_       out  m_tvalid/m_tready    tdata: red, green, blue; tlast: frame_end
// cfg_     in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One request per clock unless stalled. Each request reads the line buffer
// at the next two columns, so the next request finds its centre and right
// pixels registered. A result appears on m_ in the cycle after its request.
// Reset clears counts, the drain flag and the output valid; the line buffer
// holds whatever it held and is filled by the first row of each frame.
// s_tready drops only while a result is held and m_tready is low.
module sharpen_cross_kernel_filter_core #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // red [7:0], green [15:8], blue [23:16]
    input  logic        s_tuser,   // opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // red [7:0], green [15:8], blue [23:16]
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import scf_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int LW = (CW + 1 > CFG_WIDTH_BITS) ? CW + 1 : CFG_WIDTH_BITS;
    localparam logic [LW-1:0] MAX_W = LW'(MAX_WIDTH);

    logic [CFG_WIDTH_BITS-1:0]  width_reg;
    logic [CFG_HEIGHT_BITS-1:0] height_reg;
    logic [CW-1:0]              col_reg,  col_next;
    logic [15:0]                row_reg,  row_next;
    logic                       drain_reg, drain_next;
    rgb_t                       left_reg;
    logic                       ovalid_reg, ovalid_next;
    rgb_t                       opix_reg;
    logic                       olast_reg;

    logic          active, produce, row0, last_col;
    logic [CW:0]   c_plus;
    logic [LW-1:0] c_plus_x;
    logic [15:0]   row_inc, height_eff;
    logic [CW-1:0] nxt_col, nxt_col1;
    rgb_t          px, ctr, up, lft, rgt, down, res;
    line_entry_t   cur, pre, wdata;

    assign cfg_ready = 1'b1;
    assign s_tready  = !ovalid_reg || m_tready;
    assign px        = rgb_t'(s_tdata);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CFG_WIDTH_BITS'(640);
            height_reg <= CFG_HEIGHT_BITS'(480);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data[CFG_WIDTH_BITS-1:0];
                REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Requests whose opcode does not match the drain phase are dropped.
    assign active = s_tvalid && s_tready && (s_tuser == drain_reg);
    assign row0   = (row_reg == 16'd0);
    assign produce = active && (drain_reg || !row0);

    assign c_plus   = {1'b0, col_reg} + {{CW{1'b0}}, 1'b1};
    assign c_plus_x = LW'(c_plus);
    // A zero width acts as one, a width beyond the buffer as the buffer depth.
    assign last_col = (width_reg == '0) || (c_plus_x >= LW'(width_reg))
                   || (c_plus_x == MAX_W);
    assign nxt_col  = last_col ? '0 : c_plus[CW-1:0];
    assign nxt_col1 = nxt_col + CW'(1);

    assign ctr  = cur.centre;
    assign up   = cur.above;
    assign lft  = (col_reg == '0) ? ctr : left_reg;
    assign rgt  = last_col ? ctr : pre.centre;
    assign down = drain_reg ? ctr : px;

    always_comb
    begin
        wdata.centre = px;
        wdata.above  = row0 ? px : ctr;
    end

    scf_line_buf #(
        .DEPTH(MAX_WIDTH)
    ) u_line_buf (
        .clk       (clk),
        .wr_en     (active && !drain_reg),
        .wr_addr   (col_reg),
        .wr_data   (wdata),
        .rd_en     (active),
        .rd_addr_a (nxt_col),
        .rd_addr_b (nxt_col1),
        .rd_data_a (cur),
        .rd_data_b (pre)
    );

    scf_kernel u_kernel (
        .up   (up),
        .ctr  (ctr),
        .down (down),
        .lft  (lft),
        .rgt  (rgt),
        .pix  (res)
    );

    assign row_inc    = row_reg + 16'd1;
    assign height_eff = (height_reg == '0) ? 16'd1 : height_reg;

    always_comb
    begin
        col_next   = col_reg;
        row_next   = row_reg;
        drain_next = drain_reg;
        if (active)
        begin
            col_next = nxt_col;
            if (last_col)
            begin
                if (drain_reg)
                begin
                    row_next   = '0;
                    drain_next = 1'b0;
                end
                else
                begin
                    row_next = row_inc;
                    if ((row_inc >= height_eff) || (row_inc == 16'd0))
                    begin
                        drain_next = 1'b1;
                    end
                end
            end
        end
    end

    always_comb
    begin
        priority if (produce)
        begin
            ovalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            ovalid_next = 1'b0;
        end
        else
        begin
            ovalid_next = ovalid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg    <= '0;
            row_reg    <= '0;
            drain_reg  <= 1'b0;
            left_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            col_reg    <= col_next;
            row_reg    <= row_next;
            drain_reg  <= drain_next;
            ovalid_reg <= ovalid_next;
            if (active)
            begin
                left_reg <= ctr;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (produce)
        begin
            opix_reg  <= res;
            olast_reg <= drain_reg && last_col;
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = opix_reg;
    assign m_tlast  = olast_reg;

endmodule

// ===== design/scf_checker.sv =====
module scf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tlast
);

    // A held result keeps its payload.
    a_hold_payload: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("result payload changed while stalled");

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // With the output register empty the input side must take requests.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output register");

    // A new result is always caused by a request in the cycle before.
    a_result_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready))
        else $error("result without a request");

    // The frame end mark only comes from a drain request.
    a_last_from_drain: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) && m_tlast |-> $past(s_tuser))
        else $error("frame end from a pixel request");

endmodule

bind sharpen_cross_kernel_filter_core scf_checker u_scf_checker (.*);

// ===== tb/tb_sharpen_cross_kernel_filter_core.sv =====
`timescale 1ns / 100ps

module tb_sharpen_cross_kernel_filter_core;
    import scf_pkg::*;

    localparam int MAX_W        = 1024;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int RANDOM_ITEMS = 450;
    localparam int HOLD_CYCLES  = 300;
    localparam int WIDE_DRAINS  = 400;

    typedef struct packed {
        rgb_t px;
        logic last;
    } out_pix_t;

    typedef struct {
        bit          is_cfg;
        logic [1:0]  reg_idx;
        logic [15:0] reg_val;
        logic        op;
        rgb_t        px;
        bit          typed;
        rgb_t        want;
        logic        want_last;
    } step_row_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;

    // Shadow of the filter state, kept in step with every accepted request.
    rgb_t        above_line  [MAX_W];
    rgb_t        centre_line [MAX_W];
    rgb_t        left_px     = '0;
    int unsigned col_idx     = 0;
    logic [15:0] rows_done   = '0;
    logic        flushing    = 1'b0;
    logic [10:0] width_reg   = 11'd640;
    logic [15:0] height_reg  = 16'd480;

    out_pix_t    expected_pixels[$];
    out_pix_t    want_px;
    rgb_t        got_px;
    int          mismatches    = 0;
    int          cycles        = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          items_sent    = 0;
    logic        hold_request  = 1'b0;
    bit          hold_done     = 1'b0;
    int          hold_left     = 0;
    step_row_t   directed_steps[$];

    sharpen_cross_kernel_filter_core #(
        .MAX_WIDTH (MAX_W)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic rgb_t pix(input logic [7:0] r, input logic [7:0] g,
                                 input logic [7:0] b);
        rgb_t p;
        p.red   = r;
        p.green = g;
        p.blue  = b;
        return p;
    endfunction

    function automatic logic [7:0] rand_chan();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 15)
            return 8'h00;
        if (pick < 30)
            return 8'hFF;
        return 8'($urandom);
    endfunction

    function automatic logic [7:0] lap_channel(input logic [7:0] c, input logic [7:0] u,
                                               input logic [7:0] d, input logic [7:0] l,
                                               input logic [7:0] r);
        int v;
        v = 5 * int'(c) - int'(u) - int'(d) - int'(l) - int'(r);
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return 8'(v);
    endfunction

    function automatic rgb_t sharpen_px(input rgb_t up, input rgb_t ctr, input rgb_t dn,
                                        input rgb_t lf, input rgb_t rt);
        rgb_t res;
        res.red   = lap_channel(ctr.red, up.red, dn.red, lf.red, rt.red);
        res.green = lap_channel(ctr.green, up.green, dn.green, lf.green, rt.green);
        res.blue  = lap_channel(ctr.blue, up.blue, dn.blue, lf.blue, rt.blue);
        return res;
    endfunction

    // Advances the shadow state by one request; returns 1 when it yields a pixel.
    function automatic bit sharpen_advance(input logic op, input rgb_t px,
                                           output rgb_t res, output logic fend);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        bit          at_end;
        rgb_t        ctr;
        rgb_t        up;
        rgb_t        lft;
        rgb_t        rgt;
        bit          made;
        w = (width_reg == 0) ? 1 : ((width_reg > MAX_W) ? MAX_W : width_reg);
        h = (height_reg == 0) ? 1 : height_reg;
        c = (col_idx >= MAX_W) ? MAX_W - 1 : col_idx;
        at_end = (c + 1 >= w);
        res  = '0;
        fend = 1'b0;
        made = 1'b0;
        if (op != flushing)
            return 1'b0;
        ctr = centre_line[c];
        up  = above_line[c];
        lft = (c == 0) ? ctr : left_px;
        rgt = at_end ? ctr : centre_line[c + 1];
        if (op == OP_PIXEL)
        begin
            if (rows_done == 0)
            begin
                // The first row serves as its own upper neighbour.
                above_line[c]  = px;
                centre_line[c] = px;
            end
            else
            begin
                res  = sharpen_px(up, ctr, px, lft, rgt);
                made = 1'b1;
                above_line[c]  = ctr;
                centre_line[c] = px;
            end
            left_px = ctr;
            if (at_end)
            begin
                col_idx   = 0;
                rows_done = rows_done + 16'd1;
                if (rows_done >= h || rows_done == 0)
                    flushing = 1'b1;
            end
            else
                col_idx = c + 1;
        end
        else
        begin
            res  = sharpen_px(up, ctr, ctr, lft, rgt);
            fend = at_end;
            made = 1'b1;
            left_px = ctr;
            if (at_end)
            begin
                col_idx   = 0;
                rows_done = '0;
                flushing  = 1'b0;
            end
            else
                col_idx = c + 1;
        end
        return made;
    endfunction

    function automatic step_row_t cfg_row(input logic [1:0] idx, input logic [15:0] val);
        step_row_t s;
        s = '{default: '0};
        s.is_cfg  = 1'b1;
        s.reg_idx = idx;
        s.reg_val = val;
        return s;
    endfunction

    function automatic step_row_t item_row(input logic op, input rgb_t px);
        step_row_t s;
        s = '{default: '0};
        s.op = op;
        s.px = px;
        return s;
    endfunction

    function automatic step_row_t typed_row(input logic op, input rgb_t px,
                                            input rgb_t want, input logic want_last);
        step_row_t s;
        s = item_row(op, px);
        s.typed     = 1'b1;
        s.want      = want;
        s.want_last = want_last;
        return s;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= 40)
            $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // Receiver side: random stalls, plus one long hold-off on request.
    always @(posedge clk)
    begin
        if (hold_request && !hold_done)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got_px = m_tdata;
            if (expected_pixels.size() == 0)
                report_mismatch("result with nothing expected, red", got_px.red, 0);
            else
            begin
                want_px = expected_pixels.pop_front();
                if (got_px.red !== want_px.px.red)
                    report_mismatch("red", got_px.red, want_px.px.red);
                if (got_px.green !== want_px.px.green)
                    report_mismatch("green", got_px.green, want_px.px.green);
                if (got_px.blue !== want_px.px.blue)
                    report_mismatch("blue", got_px.blue, want_px.px.blue);
                if (m_tlast !== want_px.last)
                    report_mismatch("frame end", m_tlast, want_px.last);
            end
        end
    end

    task automatic send_item(input logic op, input rgb_t px);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= px;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic deliver(input logic op, input rgb_t px);
        rgb_t res;
        logic fend;
        if (op == flushing)
            items_sent++;
        send_item(op, px);
        if (sharpen_advance(op, px, res, fend))
            expected_pixels.push_back('{px: res, last: fend});
    endtask

    // Lets the block go idle: every result received and the pipeline empty.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_IMAGE_WIDTH)
            width_reg = val[10:0];
        else if (idx == REG_IMAGE_HEIGHT)
            height_reg = val;
        @(posedge clk);
    endtask

    // Sends one frame, following the shadow state to know when to drain.
    // A nonzero cut_rows lowers the height once that many rows are in.
    // A nonzero cut_drain narrows the width once that many drain requests are in.
    task automatic run_frame(input int cut_rows, input bit hold_on_drain, input bit reshape,
                             input int cut_drain);
        bit          done;
        bit          was_flush;
        logic        op;
        int unsigned new_w;
        done = 1'b0;
        while (!done)
        begin
            if (cut_rows > 0 && !flushing && col_idx == 0 && rows_done == cut_rows)
            begin
                settle();
                cfg_write(REG_IMAGE_HEIGHT, 16'($urandom_range(1, cut_rows)));
                cut_rows = 0;
            end
            // Narrowing mid-row ends the current row at once; never widen mid-frame.
            if (reshape && !flushing && col_idx >= 2 && $urandom_range(99) < 5)
            begin
                settle();
                new_w = $urandom_range(1, col_idx);
                cfg_write(REG_IMAGE_WIDTH, 16'(new_w));
                reshape = 1'b0;
            end
            // Narrowing mid-drain ends the frame at the next drain request.
            if (cut_drain > 0 && flushing && col_idx == cut_drain)
            begin
                settle();
                cfg_write(REG_IMAGE_WIDTH, 16'($urandom_range(1, cut_drain)));
                cut_drain = 0;
            end
            if (hold_on_drain && flushing)
            begin
                hold_request <= 1'b1;
                hold_on_drain = 1'b0;
            end
            if ($urandom_range(99) < 3)
            begin
                op = flushing ? OP_PIXEL : OP_DRAIN;
                deliver(op, pix(rand_chan(), rand_chan(), rand_chan()));
            end
            op = flushing ? OP_DRAIN : OP_PIXEL;
            was_flush = flushing;
            deliver(op, pix(rand_chan(), rand_chan(), rand_chan()));
            if (was_flush && !flushing)
                done = 1'b1;
        end
    endtask

    initial
    begin
        rgb_t        res;
        logic        fend;
        bit          made;
        int          target;
        int          frame_no;
        int unsigned w;
        int unsigned h;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_steps = '{
            item_row(OP_DRAIN, pix(8'h00, 8'h00, 8'h00)),
            cfg_row(REG_IMAGE_WIDTH, 16'd1),
            cfg_row(REG_IMAGE_HEIGHT, 16'd0),
            item_row(OP_PIXEL, pix(8'hFF, 8'hFF, 8'hFF)),
            item_row(OP_PIXEL, pix(8'h00, 8'h00, 8'h00)),
            typed_row(OP_DRAIN, pix(8'h12, 8'h34, 8'h56), pix(8'hFF, 8'hFF, 8'hFF), 1'b1),
            cfg_row(REG_IMAGE_WIDTH, 16'd3),
            cfg_row(REG_IMAGE_HEIGHT, 16'd2),
            item_row(OP_PIXEL, pix(8'h00, 8'h00, 8'h00)),
            item_row(OP_PIXEL, pix(8'hFF, 8'hFF, 8'hFF)),
            item_row(OP_PIXEL, pix(8'h00, 8'h00, 8'h00)),
            typed_row(OP_PIXEL, pix(8'h00, 8'h00, 8'h00), pix(8'h00, 8'h00, 8'h00), 1'b0),
            typed_row(OP_PIXEL, pix(8'h00, 8'h00, 8'h00), pix(8'hFF, 8'hFF, 8'hFF), 1'b0),
            typed_row(OP_PIXEL, pix(8'h00, 8'h00, 8'h00), pix(8'h00, 8'h00, 8'h00), 1'b0),
            typed_row(OP_DRAIN, pix(8'h00, 8'h00, 8'h00), pix(8'h00, 8'h00, 8'h00), 1'b0),
            typed_row(OP_DRAIN, pix(8'h00, 8'h00, 8'h00), pix(8'h00, 8'h00, 8'h00), 1'b0),
            typed_row(OP_DRAIN, pix(8'h00, 8'h00, 8'h00), pix(8'h00, 8'h00, 8'h00), 1'b1),
            cfg_row(REG_IMAGE_WIDTH, 16'd0),
            cfg_row(REG_IMAGE_HEIGHT, 16'd2),
            item_row(OP_PIXEL, pix(8'h12, 8'hC8, 8'h07)),
            item_row(OP_PIXEL, pix(8'hF0, 8'h03, 8'h81)),
            item_row(OP_DRAIN, pix(8'h5A, 8'hA5, 8'h3C))
        };

        foreach (directed_steps[i])
        begin
            if (directed_steps[i].is_cfg)
            begin
                settle();
                cfg_write(directed_steps[i].reg_idx, directed_steps[i].reg_val);
            end
            else
            begin
                send_item(directed_steps[i].op, directed_steps[i].px);
                made = sharpen_advance(directed_steps[i].op, directed_steps[i].px, res, fend);
                if (directed_steps[i].typed)
                    expected_pixels.push_back('{px: directed_steps[i].want,
                                                last: directed_steps[i].want_last});
                else if (made)
                    expected_pixels.push_back('{px: res, last: fend});
            end
        end

        // Widest row, with the receiver holding off while the drain requests pile up;
        // the drain row is cut short by narrowing the width.
        send_idle_pct = 55;
        settle();
        cfg_write(REG_IMAGE_WIDTH, 16'hFFFF);
        cfg_write(REG_IMAGE_HEIGHT, 16'd1);
        run_frame(0, 1'b1, 1'b0, WIDE_DRAINS);

        // Tallest frame, cut short after a few rows by lowering the height.
        recv_stall_pct = 55;
        settle();
        cfg_write(REG_IMAGE_WIDTH, 16'd1);
        cfg_write(REG_IMAGE_HEIGHT, 16'hFFFF);
        run_frame(6, 1'b0, 1'b0, 0);

        target   = items_sent + RANDOM_ITEMS;
        frame_no = 0;
        while (items_sent < target)
        begin
            case (frame_no % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 55; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 55; end
                default: begin send_idle_pct = 7;  recv_stall_pct = 7;  end
            endcase
            settle();
            w = ($urandom_range(99) < 85) ? $urandom_range(1, 12) : $urandom_range(13, 64);
            if ($urandom_range(49) == 0)
                w = 0;
            h = ($urandom_range(29) == 0) ? 0 : $urandom_range(1, 6);
            if ($urandom_range(9) != 0)
                cfg_write(REG_IMAGE_WIDTH, 16'(w));
            if ($urandom_range(9) != 0)
                cfg_write(REG_IMAGE_HEIGHT, 16'(h));
            run_frame(($urandom_range(9) == 0) ? int'($urandom_range(1, 3)) : 0,
                      1'b0, ($urandom_range(9) == 0), 0);
            frame_no++;
        end

        settle();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
